/* hdl/sbce_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the stereo biquad cascade equalizer.
// No dependencies; used by sbce_mac and stereo_biquad_cascade_equalizer.
package sbce_pkg;

  // Sizes of the filter cascade and its number formats.
  localparam int BANDS       = 5;
  localparam int NCOEF       = 5;
  localparam int COEF_WIDTH  = 24;
  localparam int COEF_FRAC   = 20;
  localparam int STATE_WIDTH = 32;
  localparam int STATE_FRAC  = 23;
  localparam int SAMPLE_W    = 16;
  localparam int SAMPLE_FRAC = 15;
  localparam int ACC_W       = 64;
  localparam int CDEPTH      = BANDS * NCOEF;
  localparam int FDEPTH      = BANDS * 8;
  localparam int CAW         = $clog2(CDEPTH);
  localparam int FAW         = $clog2(FDEPTH);
  localparam int BAND_W      = 3;
  localparam int SEL_W       = 3;
  localparam int KW          = 3;
  localparam int CNT_W       = $clog2(COEF_WIDTH + 1);

  // Item kinds on the input stream.
  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_COEF   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // Coefficient slots within one band; state slots within one channel.
  localparam logic [KW-1:0] K_B0 = 3'd0;
  localparam logic [KW-1:0] K_B1 = 3'd1;
  localparam logic [KW-1:0] K_B2 = 3'd2;
  localparam logic [KW-1:0] K_A1 = 3'd3;
  localparam logic [KW-1:0] K_A2 = 3'd4;
  localparam logic [1:0] ST_X1 = 2'd0;
  localparam logic [1:0] ST_X2 = 2'd1;
  localparam logic [1:0] ST_Y1 = 2'd2;
  localparam logic [1:0] ST_Y2 = 2'd3;

  localparam logic signed [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(1 << COEF_FRAC);

  typedef enum logic [2:0] {
    S_IDLE, S_RADDR, S_RDATA, S_MUL, S_WB, S_CONV, S_OUT
  } state_t;

  // Commands from the sequencer to the serial multiply-accumulate unit.
  typedef struct packed {
    logic start;
    logic first;
    logic neg;
  } mac_ctl_t;

endpackage

/* hdl/sbce_mac.sv */
`timescale 1ns / 1ps
// Bit-serial signed multiply-accumulate: one coefficient bit per cycle.
// Depends on sbce_pkg.
module sbce_mac (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  sbce_pkg::mac_ctl_t                     ctl,
  input  logic signed [sbce_pkg::STATE_WIDTH-1:0] op,
  input  logic signed [sbce_pkg::COEF_WIDTH-1:0]  coef,
  output logic                                   busy,
  output logic signed [sbce_pkg::ACC_W-1:0]       acc
);
  import sbce_pkg::*;

  logic signed [ACC_W-1:0]      mcand_r, mcand_nxt;
  logic        [COEF_WIDTH-1:0] mult_r, mult_nxt;
  logic        [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                         neg_r, neg_nxt;
  logic signed [ACC_W-1:0]      acc_r, acc_nxt;
  logic signed [ACC_W-1:0]      term;
  logic                         sub;

  // One partial product per cycle; the coefficient's top bit has negative weight.
  always_comb begin
    mcand_nxt = mcand_r;
    mult_nxt  = mult_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    term      = mult_r[0] ? mcand_r : '0;
    sub       = neg_r ^ (cnt_r == CNT_W'(1));
    if (ctl.start) begin
      mcand_nxt = ACC_W'(op);
      mult_nxt  = coef;
      cnt_nxt   = CNT_W'(COEF_WIDTH);
      neg_nxt   = ctl.neg;
      if (ctl.first) begin
        acc_nxt = '0;
      end
    end else if (cnt_r != '0) begin
      acc_nxt   = sub ? acc_r - term : acc_r + term;
      mcand_nxt = mcand_r <<< 1;
      mult_nxt  = mult_r >> 1;
      cnt_nxt   = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    mcand_r <= mcand_nxt;
    mult_r  <= mult_nxt;
    neg_r   <= neg_nxt;
    acc_r   <= acc_nxt;
  end

  assign busy = (cnt_r != '0);
  assign acc  = acc_r;

endmodule

/* hdl/stereo_biquad_cascade_equalizer.sv */
`timescale 1ns / 1ps
// Top level of the stereo five-band biquad equalizer: sequencer, memories, I/O.
// Depends on sbce_pkg and sbce_mac.
//
//  Channel   Ports                        Direction  Content
//  input     in_tvalid/in_tready/in_tdata  in         mode, samples, coefficient write
//  output    out_tvalid/out_tready/out_tdata out      filtered left and right samples
//  config    cfg_we/cfg_wdata             in         enabled
//
// A filtered pair runs the left and then the right channel through every band, with the
// bit-serial multiplier doing one coefficient bit per cycle over 50 products. Coefficient
// writes and clears are accepted while staying idle; bypassed pairs go straight to output.
// Reset marks every memory entry invalid; invalid entries read as zero, b0 coefficients as one.
// A finished pair waits in the output register while the next item is accepted.
module stereo_biquad_cascade_equalizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // mode[1:0], left_in[17:2], right_in[33:18],
                                  // band[36:34], coef_select[39:37], coef_value[63:40]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // left_out[15:0], right_out[31:16]
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  import sbce_pkg::*;

  // Input field split.
  logic        [1:0]             in_mode;
  logic signed [SAMPLE_W-1:0]    in_left, in_right;
  logic        [BAND_W-1:0]      in_band;
  logic        [SEL_W-1:0]       in_sel;
  logic signed [COEF_WIDTH-1:0]  in_coef;
  logic                          in_acc;

  assign in_mode  = in_tdata[1:0];
  assign in_left  = in_tdata[17:2];
  assign in_right = in_tdata[33:18];
  assign in_band  = in_tdata[36:34];
  assign in_sel   = in_tdata[39:37];
  assign in_coef  = in_tdata[63:40];

  state_t                        st_r, st_nxt;
  logic                          en_r;
  logic                          ch_r, ch_nxt;
  logic        [BAND_W-1:0]      band_r, band_nxt;
  logic        [KW-1:0]          k_r, k_nxt;
  logic        [1:0]             wb_r, wb_nxt;
  logic signed [STATE_WIDTH-1:0] x_r, x_nxt, s0_r, s0_nxt, s2_r, s2_nxt, y_r, y_nxt;
  logic signed [SAMPLE_W-1:0]    rin_r, rin_nxt, resl_r, resl_nxt, resr_r, resr_nxt;
  logic                          ov_r, ov_nxt;
  logic        [31:0]            od_r, od_nxt;

  // Memories and their valid bits.
  logic signed [COEF_WIDTH-1:0]  cmem [CDEPTH];
  logic signed [STATE_WIDTH-1:0] fmem [FDEPTH];
  logic        [CDEPTH-1:0]      cvld_r;
  logic        [FDEPTH-1:0]      fvld_r;
  logic signed [COEF_WIDTH-1:0]  cq_r;
  logic signed [STATE_WIDTH-1:0] fq_r;
  logic                          cqv_r, fqv_r;
  logic        [CAW-1:0]         c_ra, c_wa;
  logic        [FAW-1:0]         f_ra, f_wa, f_base;
  logic                          c_we, f_we;
  logic signed [STATE_WIDTH-1:0] f_wd;

  mac_ctl_t                      mctl;
  logic signed [STATE_WIDTH-1:0] m_op;
  logic signed [COEF_WIDTH-1:0]  m_coef;
  logic                          m_busy;
  logic signed [ACC_W-1:0]       m_acc;

  logic signed [ACC_W-1:0]       acc_sh;
  logic signed [STATE_WIDTH-1:0] y_sat;
  logic signed [STATE_WIDTH-1:0] yc;
  logic signed [40:0]            prod;
  logic signed [SAMPLE_W-1:0]    conv;
  logic                          coef_ok;

  assign in_tready = (st_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign coef_ok   = (32'(in_band) < BANDS) && (in_sel <= SEL_W'(NCOEF - 1));
  assign f_base    = FAW'({band_r, ch_r, 2'b00});
  assign c_ra      = CAW'(CAW'(band_r) * CAW'(NCOEF) + CAW'(k_r));
  assign f_ra      = f_base + FAW'(k_r - KW'(1));
  assign c_wa      = CAW'(CAW'(in_band) * CAW'(NCOEF) + CAW'(in_sel));
  assign c_we      = in_acc && (in_mode == MODE_COEF) && coef_ok;

  // Band output: floor shift by the coefficient fraction, then saturate.
  always_comb begin
    acc_sh = m_acc >>> COEF_FRAC;
    if (acc_sh > ((ACC_W'(1) <<< (STATE_WIDTH - 1)) - ACC_W'(1))) begin
      y_sat = {1'b0, {(STATE_WIDTH - 1){1'b1}}};
    end else if (acc_sh < -(ACC_W'(1) <<< (STATE_WIDTH - 1))) begin
      y_sat = {1'b1, {(STATE_WIDTH - 1){1'b0}}};
    end else begin
      y_sat = acc_sh[STATE_WIDTH-1:0];
    end
  end

  // Sample conversion: clamp to plus or minus one, scale by 32767, truncate toward zero.
  always_comb begin
    if (x_r > STATE_WIDTH'(1 << STATE_FRAC)) begin
      yc = STATE_WIDTH'(1 << STATE_FRAC);
    end else if (x_r < -(STATE_WIDTH'(1 << STATE_FRAC))) begin
      yc = -(STATE_WIDTH'(1 << STATE_FRAC));
    end else begin
      yc = x_r;
    end
    prod = (41'(yc) <<< 15) - 41'(yc);
    if (prod < 0) begin
      prod = prod + 41'((1 << STATE_FRAC) - 1);
    end
    conv = SAMPLE_W'(prod >>> STATE_FRAC);
  end

  // Coefficients and state operands come from the registered reads; the b0 operand is x_r.
  always_comb begin
    if (k_r == K_B0) begin
      m_op   = x_r;
      m_coef = cqv_r ? cq_r : COEF_ONE;
    end else begin
      m_op   = fqv_r ? fq_r : '0;
      m_coef = cqv_r ? cq_r : '0;
    end
  end

  // State write-back order: x2 from old x1, x1 from x, y2 from old y1, y1 from y.
  always_comb begin
    case (wb_r)
      2'd0:    begin f_wa = f_base + FAW'(ST_X2); f_wd = s0_r; end
      2'd1:    begin f_wa = f_base + FAW'(ST_X1); f_wd = x_r;  end
      2'd2:    begin f_wa = f_base + FAW'(ST_Y2); f_wd = s2_r; end
      default: begin f_wa = f_base + FAW'(ST_Y1); f_wd = y_r;  end
    endcase
  end
  assign f_we = (st_r == S_WB);

  // Sequencer: next state and datapath controls.
  always_comb begin
    st_nxt   = st_r;
    ch_nxt   = ch_r;
    band_nxt = band_r;
    k_nxt    = k_r;
    wb_nxt   = wb_r;
    x_nxt    = x_r;
    s0_nxt   = s0_r;
    s2_nxt   = s2_r;
    y_nxt    = y_r;
    rin_nxt  = rin_r;
    resl_nxt = resl_r;
    resr_nxt = resr_r;
    mctl     = '0;
    ov_nxt   = ov_r && !out_tready;
    od_nxt   = od_r;
    case (st_r)
      S_IDLE: begin
        if (in_acc && in_mode == MODE_SAMPLE) begin
          if (en_r) begin
            x_nxt    = STATE_WIDTH'(in_left) <<< (STATE_FRAC - SAMPLE_FRAC);
            rin_nxt  = in_right;
            ch_nxt   = 1'b0;
            band_nxt = '0;
            k_nxt    = K_B0;
            st_nxt   = S_RADDR;
          end else begin
            resl_nxt = in_left;
            resr_nxt = in_right;
            st_nxt   = S_OUT;
          end
        end
      end
      S_RADDR: st_nxt = S_RDATA;
      S_RDATA: begin
        mctl.start = 1'b1;
        mctl.first = (k_r == K_B0);
        mctl.neg   = (k_r >= K_A1);
        if (k_r == K_B1) s0_nxt = m_op;
        if (k_r == K_A1) s2_nxt = m_op;
        st_nxt = S_MUL;
      end
      S_MUL: begin
        if (!m_busy) begin
          if (k_r == K_A2) begin
            y_nxt  = y_sat;
            wb_nxt = 2'd0;
            st_nxt = S_WB;
          end else begin
            k_nxt  = k_r + KW'(1);
            st_nxt = S_RADDR;
          end
        end
      end
      S_WB: begin
        wb_nxt = wb_r + 2'd1;
        if (wb_r == 2'd3) begin
          x_nxt = y_r;
          k_nxt = K_B0;
          if (32'(band_r) == BANDS - 1) begin
            st_nxt = S_CONV;
          end else begin
            band_nxt = band_r + BAND_W'(1);
            st_nxt   = S_RADDR;
          end
        end
      end
      S_CONV: begin
        band_nxt = '0;
        k_nxt    = K_B0;
        if (!ch_r) begin
          resl_nxt = conv;
          ch_nxt   = 1'b1;
          x_nxt    = STATE_WIDTH'(rin_r) <<< (STATE_FRAC - SAMPLE_FRAC);
          st_nxt   = S_RADDR;
        end else begin
          resr_nxt = conv;
          st_nxt   = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = {resr_r, resl_r};
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Control registers and valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      en_r   <= 1'b1;
      ov_r   <= 1'b0;
      cvld_r <= '0;
      fvld_r <= '0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      if (cfg_we) en_r <= cfg_wdata;
      if (c_we) begin
        cvld_r[c_wa] <= 1'b1;
        fvld_r[FAW'({in_band, 3'b000}) +: 8] <= '0;
      end
      if (in_acc && in_mode == MODE_CLEAR) fvld_r <= '0;
      if (f_we) fvld_r[f_wa] <= 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    ch_r   <= ch_nxt;
    band_r <= band_nxt;
    k_r    <= k_nxt;
    wb_r   <= wb_nxt;
    x_r    <= x_nxt;
    s0_r   <= s0_nxt;
    s2_r   <= s2_nxt;
    y_r    <= y_nxt;
    rin_r  <= rin_nxt;
    resl_r <= resl_nxt;
    resr_r <= resr_nxt;
    od_r   <= od_nxt;
  end

  // Coefficient memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (c_we) cmem[c_wa] <= in_coef;
    cq_r  <= cmem[c_ra];
    cqv_r <= cvld_r[c_ra];
  end

  // Filter state memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (f_we) fmem[f_wa] <= f_wd;
    fq_r  <= fmem[f_ra];
    fqv_r <= fvld_r[f_ra];
  end

  sbce_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mctl),
    .op    (m_op),
    .coef  (m_coef),
    .busy  (m_busy),
    .acc   (m_acc)
  );

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  // The serial multiplier only runs while the sequencer waits on it.
  a_mac_busy: assert property (@(posedge clk) disable iff (!rst_n)
    m_busy |-> st_r == S_MUL) else $error("multiplier busy outside multiply state");

  // An enabled sample pair starts the band sequence.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_mode == MODE_SAMPLE && en_r) |=> st_r == S_RADDR)
    else $error("sample pair did not start filtering");

  // State write-back stays inside the filter memory.
  a_wb_addr: assert property (@(posedge clk) disable iff (!rst_n)
    f_we |-> 32'(f_wa) < FDEPTH) else $error("filter write out of range");

  // A result is loaded only when the output register can take it.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_OUT && ov_r && !out_tready) |=> st_r == S_OUT)
    else $error("result overwrote a waiting item");

endmodule
